[src/u16to8_pkg.sv]
// u16to8_pkg: shared types, constants and the UTF-8 byte encoder for the
// UTF-16 to UTF-8 transcoder. No dependencies.
package u16to8_pkg;

  localparam logic [5:0]  HIGH_TAG  = 6'h36;   // unit[15:10] of a high surrogate
  localparam logic [5:0]  LOW_TAG   = 6'h37;   // unit[15:10] of a low surrogate
  localparam logic [15:0] PAD_UNIT  = 16'hFFFF;
  localparam logic [20:0] QMARK_CP  = 21'h3F;  // '?'
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One encoded code point: up to four bytes, index of the final one.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } utf8_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic utf8_entry_t encode_cp(input logic [20:0] cp);
    utf8_entry_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.bytes[0] = {1'b0, cp[6:0]};
      e.last_idx = 2'd0;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.last_idx = 2'd1;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.last_idx = 2'd2;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

endpackage

[src/u16to8_front.sv]
// u16to8_front: accepts code units, tracks a held high surrogate and pushes
// encoded code points into the queue. Depends on u16to8_pkg.
module u16to8_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             in_code_unit,
  input  logic                    in_end_of_name,
  input  u16to8_pkg::q_stat_t     q_stat,
  output logic                    push,
  output u16to8_pkg::utf8_entry_t push_entry
);

  logic        pending_r, pending_nxt;
  logic [9:0]  high_r, high_nxt;
  logic        accept;
  logic        is_high, is_low;
  logic        emit;
  logic [20:0] cp;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign is_high  = (in_code_unit[15:10] == u16to8_pkg::HIGH_TAG);
  assign is_low   = (in_code_unit[15:10] == u16to8_pkg::LOW_TAG);

  always_comb begin
    pending_nxt = pending_r;
    high_nxt    = high_r;
    emit        = 1'b0;
    cp          = {5'd0, in_code_unit};
    if (accept) begin
      priority if (pending_r) begin
        // partner slot: always consumed
        pending_nxt = 1'b0;
        high_nxt    = '0;
        emit        = 1'b1;
        cp = is_low ? ({1'b0, high_r, in_code_unit[9:0]} + u16to8_pkg::SUPP_BASE)
                    : u16to8_pkg::QMARK_CP;
      end else if (in_code_unit == u16to8_pkg::PAD_UNIT) begin
        emit = 1'b0;
      end else if (is_high) begin
        if (in_end_of_name) begin
          emit = 1'b1;
          cp   = u16to8_pkg::QMARK_CP;
        end else begin
          pending_nxt = 1'b1;
          high_nxt    = in_code_unit[9:0];
        end
      end else begin
        emit = 1'b1;
      end
    end
  end

  assign push       = emit;
  assign push_entry = u16to8_pkg::encode_cp(cp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      high_r    <= '0;
    end else begin
      pending_r <= pending_nxt;
      high_r    <= high_nxt;
    end
  end

  a_pair_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pending_r) |=> !pending_r)
    else $error("held surrogate not released after partner unit");

endmodule

[src/u16to8_queue.sv]
// u16to8_queue: small FIFO of encoded code points between front and back.
// Depends on u16to8_pkg.
module u16to8_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  u16to8_pkg::utf8_entry_t push_entry,
  input  logic                    pop,
  output u16to8_pkg::utf8_entry_t head,
  output u16to8_pkg::q_stat_t     q_stat
);

  u16to8_pkg::utf8_entry_t           slot_r [u16to8_pkg::QDEPTH];
  logic [u16to8_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [u16to8_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign q_stat.full  = (count_r == u16to8_pkg::QCNT_W'(u16to8_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= u16to8_pkg::QCNT_W'(u16to8_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule

[src/u16to8_back.sv]
// u16to8_back: takes encoded code points from the queue and sends them out
// one byte per transaction. Depends on u16to8_pkg.
module u16to8_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  u16to8_pkg::q_stat_t     q_stat,
  input  u16to8_pkg::utf8_entry_t head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_utf8_byte,
  output logic                    out_last_byte
);

  u16to8_pkg::utf8_entry_t cur_r;
  logic                    cur_valid_r;
  logic [1:0]              idx_r;
  logic                    take, at_last, load;

  assign out_valid     = cur_valid_r;
  assign out_utf8_byte = cur_r.bytes[idx_r];
  assign at_last       = (idx_r == cur_r.last_idx);
  assign out_last_byte = at_last;
  assign take          = cur_valid_r && out_ready;
  // refill when idle or when the final byte leaves this cycle
  assign load          = !cur_valid_r || (take && at_last);
  assign pop           = load && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      cur_valid_r <= !q_stat.empty;
      idx_r       <= '0;
    end else if (take) begin
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule

[src/utf16_to_utf8_transcoder_unit.sv]
// utf16_to_utf8_transcoder_unit: top level of the UTF-16 to UTF-8 transcoder.
// Depends on u16to8_pkg, u16to8_front, u16to8_queue, u16to8_back.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, in_code_unit[15:0],  | into block
//          | in_end_of_name                          |
//  out     | out_valid, out_ready, out_utf8_byte[7:0], | out of block
//          | out_last_byte                           |
//
// Cycles: one input transaction per cycle while the queue has room; output
//   runs at one byte per cycle while out_ready is high and the queue holds
//   entries; a code point is 1 to 4 bytes (3 for a BMP unit above 0x7FF).
// Path: with the back end idle, an emitting unit is written into the queue
//   as it is accepted, then into the back end's byte register, which drives
//   its first byte.
// Reset: synchronous active low; clears the held surrogate, queue pointers
//   and the output valid.
// Stalls: a 4-entry queue decouples the sides; in_ready drops only when the
//   queue is full, and out_valid holds with stable data until out_ready.
module utf16_to_utf8_transcoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        in_end_of_name,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_utf8_byte,
  output logic        out_last_byte
);

  u16to8_pkg::q_stat_t     q_stat;
  u16to8_pkg::utf8_entry_t push_entry;
  u16to8_pkg::utf8_entry_t head;
  logic                    push;
  logic                    pop;

  // front: classify units, pair surrogates, encode
  u16to8_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_unit   (in_code_unit),
    .in_end_of_name (in_end_of_name),
    .q_stat         (q_stat),
    .push           (push),
    .push_entry     (push_entry)
  );

  // queue of encoded code points
  u16to8_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // back: serialize bytes to the output channel
  u16to8_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_utf8_byte (out_utf8_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

[dv/utf16_to_utf8_transcoder_unit_test.sv]
// utf16_to_utf8_transcoder_unit_test: self-checking bench for the UTF-16 to UTF-8
// transcoder. A directed table and random surrogate-heavy traffic are scored against
// an in-bench predictor. Depends on u16to8_pkg and utf16_to_utf8_transcoder_unit.
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_unit_test;

  localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES  = 20;    // settle time after the last expected byte
  localparam int ITEMS_PER_PHASE = 71;  // four random phases plus the table, about 310 units
  localparam int PRINT_CAP     = 40;

  // One output transaction: a byte plus the end-of-code-point flag.
  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } utf8_out_t;

  // How a driven unit is scored: typed bytes, or whatever the predictor says.
  typedef struct packed {
    logic            typed;
    logic [2:0]      n;
    logic [0:3][7:0] seq;
  } utf8_plan_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        eon;
    utf8_plan_t  plan;
  } stim_row_t;

  localparam utf8_plan_t PREDICTED = '0;
  localparam int N_ROWS = 25;

  // Directed table. Typed rows carry their bytes; the rest go through the predictor.
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{16'h0000, 1'b0, '{1'b1, 3'd1, 32'h00000000}},  // smallest unit, first after reset
    '{16'h007F, 1'b0, '{1'b1, 3'd1, 32'h7F000000}},  // top of one-byte range
    '{16'h0080, 1'b0, '{1'b1, 3'd2, 32'hC2800000}},  // bottom of two-byte range
    '{16'h07FF, 1'b0, '{1'b1, 3'd2, 32'hDFBF0000}},  // top of two-byte range
    '{16'h0800, 1'b0, '{1'b1, 3'd3, 32'hE0A08000}},  // bottom of three-byte range
    '{16'hFFFF, 1'b0, '{1'b1, 3'd0, 32'h00000000}},  // padding, skipped
    '{16'hFFFE, 1'b1, '{1'b1, 3'd3, 32'hEFBFBE00}},  // largest non-pad unit
    '{16'hD800, 1'b0, '{1'b1, 3'd0, 32'h00000000}},  // high half held
    '{16'hDC00, 1'b0, '{1'b1, 3'd4, 32'hF0908080}},  // pair -> U+10000
    '{16'hDBFF, 1'b0, '{1'b1, 3'd0, 32'h00000000}},
    '{16'hDFFF, 1'b1, '{1'b1, 3'd4, 32'hF48FBFBF}},  // pair -> U+10FFFF
    '{16'hD800, 1'b1, '{1'b1, 3'd1, 32'h3F000000}},  // high half ends the name
    '{16'hDC00, 1'b0, '{1'b1, 3'd3, 32'hEDB08000}},  // lone low half
    '{16'hDFFF, 1'b1, '{1'b1, 3'd3, 32'hEDBFBF00}},
    '{16'hD9AB, 1'b0, '{1'b1, 3'd0, 32'h00000000}},
    '{16'h0041, 1'b0, '{1'b1, 3'd1, 32'h3F000000}},  // non-low partner dropped
    '{16'hDA00, 1'b0, '{1'b1, 3'd0, 32'h00000000}},
    '{16'hFFFF, 1'b1, '{1'b1, 3'd1, 32'h3F000000}},  // pad as partner is consumed
    '{16'hDB00, 1'b0, '{1'b1, 3'd0, 32'h00000000}},
    '{16'hD800, 1'b0, '{1'b1, 3'd1, 32'h3F000000}},  // high as partner, not re-held
    '{16'h0042, 1'b1, PREDICTED},
    '{16'hD801, 1'b0, PREDICTED},
    '{16'hDC37, 1'b1, PREDICTED},
    '{16'hDBFF, 1'b0, PREDICTED},
    '{16'hDBFF, 1'b1, PREDICTED}                     // second high half as partner
  };

  // DUT ports; the inputs are known from time zero.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_code_unit = '0;
  logic        in_end_of_name = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_utf8_byte;
  logic        out_last_byte;

  // Predictor state: the held high surrogate.
  logic        held_valid = 1'b0;
  logic [9:0]  held_bits = '0;

  utf8_out_t   utf8_expected [$];   // bytes still owed by the block, oldest first
  utf8_out_t   predicted_bytes [$]; // scratch, filled per accepted unit
  utf8_plan_t  unit_plans [$];      // one per driven unit, popped on acceptance

  int          err_count = 0;
  int          quiet_cycles = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  utf16_to_utf8_transcoder_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_unit   (in_code_unit),
    .in_end_of_name (in_end_of_name),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_utf8_byte  (out_utf8_byte),
    .out_last_byte  (out_last_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  // Appends the UTF-8 bytes of one code point to the scratch queue.
  function automatic void push_code_point(input logic [20:0] cp);
    logic [7:0] b [4];
    int n;
    if (cp < 21'h80) begin
      b[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      b[0] = 8'hC0 | 8'(cp >> 6);
      b[1] = 8'h80 | {2'b00, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      b[0] = 8'hE0 | {4'h0, cp[15:12]};
      b[1] = 8'h80 | {2'b00, cp[11:6]};
      b[2] = 8'h80 | {2'b00, cp[5:0]};
      n = 3;
    end else begin
      b[0] = 8'hF0 | {5'h00, cp[20:18]};
      b[1] = 8'h80 | {2'b00, cp[17:12]};
      b[2] = 8'h80 | {2'b00, cp[11:6]};
      b[3] = 8'h80 | {2'b00, cp[5:0]};
      n = 4;
    end
    for (int k = 0; k < n; k++) predicted_bytes.push_back('{b[k], k == n - 1});
  endfunction

  // Transcoder behavior for one accepted unit; updates the held surrogate.
  function automatic void predict_utf8(input logic [15:0] unit, input logic eon);
    predicted_bytes.delete();
    if (held_valid) begin
      // Whatever follows a held high half is its partner, pad included.
      held_valid = 1'b0;
      if (unit[15:10] == u16to8_pkg::LOW_TAG)
        push_code_point({1'b0, held_bits, unit[9:0]} + u16to8_pkg::SUPP_BASE);
      else push_code_point(u16to8_pkg::QMARK_CP);
      held_bits = '0;
    end else if (unit == u16to8_pkg::PAD_UNIT) begin
      // skipped, nothing out
    end else if (unit[15:10] == u16to8_pkg::HIGH_TAG) begin
      if (eon) begin
        push_code_point(u16to8_pkg::QMARK_CP);
      end else begin
        held_valid = 1'b1;
        held_bits  = unit[9:0];
      end
    end else begin
      push_code_point({5'b0, unit});
    end
  endfunction

  // Scoreboard. Output is checked before the same edge's input is predicted;
  // a new unit can never produce a byte on the edge it is accepted.
  always @(posedge clk) begin
    utf8_out_t  want;
    utf8_plan_t plan;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (utf8_expected.size() == 0) begin
          report_mismatch($sformatf("byte %02h last %0b with nothing expected",
                                    out_utf8_byte, out_last_byte));
        end else begin
          want = utf8_expected.pop_front();
          if (out_utf8_byte !== want.octet)
            report_mismatch($sformatf("utf8_byte got %02h want %02h",
                                      out_utf8_byte, want.octet));
          if (out_last_byte !== want.last)
            report_mismatch($sformatf("last_byte got %0b want %0b (byte %02h)",
                                      out_last_byte, want.last, want.octet));
        end
      end
      if (in_valid && in_ready) begin
        plan = (unit_plans.size() != 0) ? unit_plans.pop_front() : PREDICTED;
        predict_utf8(in_code_unit, in_end_of_name);
        if (plan.typed) begin
          for (int k = 0; k < int'(plan.n); k++)
            utf8_expected.push_back('{plan.seq[k], k == int'(plan.n) - 1});
        end else begin
          foreach (predicted_bytes[k]) utf8_expected.push_back(predicted_bytes[k]);
        end
      end
    end
  end

  // Receiver: random backpressure at the current stall rate.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= out_stall_pct);

  // Watchdog: too long with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drives one unit and returns at the edge it is accepted. in_valid is only
  // dropped when an idle gap is taken, so back-to-back units keep it high.
  task automatic send_unit(input logic [15:0] unit, input logic eon, input utf8_plan_t plan);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk);
    end
    unit_plans.push_back(plan);
    in_valid       <= 1'b1;
    in_code_unit   <= unit;
    in_end_of_name <= eon;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One random sequence of one or two units; mostly well-formed text with
  // surrogate pairs, plus broken pairs, pads and raw noise.
  task automatic send_random_seq(output int n_sent);
    int unsigned pick;
    logic [15:0] unit;
    logic [9:0]  r10;
    logic        eon;
    pick   = $urandom_range(99);
    eon    = ($urandom_range(7) == 0);
    r10    = 10'($urandom);
    n_sent = 1;
    if (pick < 15) begin
      unit = 16'($urandom_range(16'h007F, 16'h0000));
    end else if (pick < 28) begin
      unit = 16'($urandom_range(16'h07FF, 16'h0080));
    end else if (pick < 48) begin
      unit = 16'($urandom_range(16'hFFFE, 16'h0800));
      if (unit[15:11] == 5'b11011) unit = unit ^ 16'h4000;  // keep clear of surrogates
    end else if (pick < 73) begin
      send_unit({u16to8_pkg::HIGH_TAG, r10}, 1'b0, PREDICTED);
      r10    = 10'($urandom);
      unit   = {u16to8_pkg::LOW_TAG, r10};
      n_sent = 2;
    end else if (pick < 78) begin
      unit = u16to8_pkg::PAD_UNIT;
    end else if (pick < 83) begin
      unit = {u16to8_pkg::LOW_TAG, r10};
    end else if (pick < 89) begin
      unit = {u16to8_pkg::HIGH_TAG, r10};
      eon  = 1'b1;
    end else if (pick < 94) begin
      send_unit({u16to8_pkg::HIGH_TAG, r10}, 1'b0, PREDICTED);
      unit = 16'($urandom);
      while (unit[15:10] == u16to8_pkg::LOW_TAG) unit = 16'($urandom);
      n_sent = 2;
    end else begin
      unit = 16'($urandom);
      eon  = 1'($urandom_range(1));
    end
    send_unit(unit, eon, PREDICTED);
  endtask

  // Sender holds off until every owed byte has come out.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (utf8_expected.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, no idling on either side.
    for (int r = 0; r < N_ROWS; r++)
      send_unit(DIRECTED_ROWS[r].unit, DIRECTED_ROWS[r].eon, DIRECTED_ROWS[r].plan);
    drain_outputs();

    // Random phases: free-running, sparse sender, heavy backpressure, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 86;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 86;
        end
        default: begin
          in_idle_pct = 34;
          out_stall_pct = 34;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_random_seq(k);
        sent += k;
      end
      drain_outputs();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
